/* design/nfa_pkg.sv */
// ----------------------------------------------------------------------------
// nfa_pkg: shared types and constants for the NFA prefix matcher
// Table entry layout, kind and command codes, and the byte class decoder.
// ----------------------------------------------------------------------------
package nfa_pkg;

    localparam int NUM_STATES = 64;
    localparam int IDX_W      = $clog2(NUM_STATES);
    localparam int POS_BITS   = 16;
    localparam int END_W      = 16;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BEGIN = 2'd1;
    localparam logic [1:0] CMD_CHAR  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [8:0] KIND_MATCH = 9'd256;
    localparam logic [8:0] KIND_SPLIT = 9'd257;
    localparam logic [8:0] KIND_ANY   = 9'd258;
    localparam logic [8:0] KIND_DIGIT = 9'd259;
    localparam logic [8:0] KIND_WORD  = 9'd260;
    localparam logic [8:0] KIND_SPACE = 9'd261;

    typedef struct packed {
        logic [8:0]       kind;
        logic [IDX_W-1:0] next;
        logic             next_valid;
        logic [IDX_W-1:0] alt;
        logic             alt_valid;
    } nfa_entry_t;

    function automatic logic is_digit(input logic [7:0] ch);
        is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    endfunction

    function automatic logic byte_accepted(input logic [8:0] kind, input logic [7:0] ch);
        logic res;
        case (kind)
            KIND_ANY:   res = (ch != 8'h00);
            KIND_DIGIT: res = is_digit(ch);
            KIND_WORD:  res = is_digit(ch) || (ch >= 8'h61 && ch <= 8'h7a) ||
                              (ch >= 8'h41 && ch <= 8'h5a) || (ch == 8'h5f);
            KIND_SPACE: res = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0a) ||
                              (ch == 8'h0d);
            default:    res = !kind[8] && (kind[7:0] == ch);
        endcase
        byte_accepted = res;
    endfunction

endpackage

/* design/nfa_regex_prefix_matcher.sv */
// ----------------------------------------------------------------------------
// nfa_regex_prefix_matcher: anchored Thompson NFA simulation over a byte stream
// Sequence: load writes its table entry on accept; begin runs closure passes (at
//   least one) until none changes, then a final scan; char adds a step scan first.
// Throughput: one request at a time; table memory has a single read port,
//   one entry per cycle, which sets the scan length.
// Reset: rst_n async, clears active set, match record, position and start_state;
//   table contents undefined until loaded.
// ----------------------------------------------------------------------------
module nfa_regex_prefix_matcher #(
    parameter int POS_BITS = nfa_pkg::POS_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] char_in, [13:8] entry_index, [22:14] entry_kind, [28:23] entry_next,
    // [29] entry_next_valid, [35:30] entry_alt, [36] entry_alt_valid
    input  logic [nfa_pkg::IN_DATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] matched, [16:1] match_len, [17] any_active
    output logic [nfa_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nfa_pkg::IDX_W-1:0]      cfg_data
);
    import nfa_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_STEP  = 5'b00010,
        ST_CLOSE = 5'b00100,
        ST_FINAL = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    state_t                  state_reg, state_next;
    logic [IDX_W:0]          cnt_reg, cnt_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    nfa_entry_t              rd_data_reg;
    logic [NUM_STATES-1:0]   seed_reg, seed_next;
    logic [NUM_STATES-1:0]   active_reg, active_next;
    logic                    changed_reg, changed_next;
    logic                    any_reg, any_next;
    logic                    hit_reg, hit_next;
    logic [7:0]              char_reg, char_next;
    logic [POS_BITS-1:0]     position_reg, position_next;
    logic [POS_BITS-1:0]     longest_reg, longest_next;
    logic                    match_seen_reg, match_seen_next;
    logic [IDX_W-1:0]        start_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;

    nfa_entry_t              tbl_mem [NUM_STATES];
    nfa_entry_t              wr_entry;
    logic                    tbl_we;
    logic                    in_acc;
    logic                    issue, scan_done;
    logic [END_W-1:0]        end16;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign in_acc    = s_tvalid && s_tready;

    assign wr_entry.kind       = s_tdata[22:14];
    assign wr_entry.next       = s_tdata[28:23];
    assign wr_entry.next_valid = s_tdata[29];
    assign wr_entry.alt        = s_tdata[35:30];
    assign wr_entry.alt_valid  = s_tdata[36];
    assign tbl_we = in_acc && (s_tuser == CMD_LOAD);

    // table memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[s_tdata[13:8]] <= wr_entry;
        end
        rd_data_reg <= tbl_mem[cnt_reg[IDX_W-1:0]];
    end

    // scan sequencer: read data arrives in the cycle after its address is issued
    assign issue     = (state_reg != ST_IDLE) && (state_reg != ST_DONE) &&
                       (cnt_reg < (IDX_W+1)'(NUM_STATES));
    assign scan_done = !issue && !rd_vld_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = issue ? cnt_reg + 1'b1 : cnt_reg;
        rd_vld_next     = issue;
        rd_idx_next     = cnt_reg[IDX_W-1:0];
        seed_next       = seed_reg;
        active_next     = active_reg;
        changed_next    = changed_reg;
        any_next        = any_reg;
        hit_next        = hit_reg;
        char_next       = char_reg;
        position_next   = position_reg;
        longest_next    = longest_reg;
        match_seen_next = match_seen_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        end16           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cnt_next    = '0;
                    rd_vld_next = 1'b0;
                    if (s_tuser == CMD_BEGIN)
                    begin
                        match_seen_next     = 1'b0;
                        longest_next        = '0;
                        position_next       = '0;
                        seed_next           = '0;
                        seed_next[start_reg] = 1'b1;
                        changed_next        = 1'b0;
                        state_next          = ST_CLOSE;
                    end
                    else if (s_tuser == CMD_CHAR)
                    begin
                        seed_next  = '0;
                        char_next  = s_tdata[7:0];
                        if (position_reg != POS_MAX)
                        begin
                            position_next = position_reg + 1'b1;
                        end
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                if (rd_vld_reg && active_reg[rd_idx_reg] && rd_data_reg.next_valid &&
                    byte_accepted(rd_data_reg.kind, char_reg))
                begin
                    seed_next[rd_data_reg.next] = 1'b1;
                end
                if (scan_done)
                begin
                    cnt_next     = '0;
                    changed_next = 1'b0;
                    state_next   = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                if (rd_vld_reg && seed_reg[rd_idx_reg] && rd_data_reg.kind == KIND_SPLIT)
                begin
                    if (rd_data_reg.next_valid && !seed_next[rd_data_reg.next])
                    begin
                        seed_next[rd_data_reg.next] = 1'b1;
                        changed_next = 1'b1;
                    end
                    if (rd_data_reg.alt_valid && !seed_next[rd_data_reg.alt])
                    begin
                        seed_next[rd_data_reg.alt] = 1'b1;
                        changed_next = 1'b1;
                    end
                end
                if (scan_done)
                begin
                    cnt_next     = '0;
                    changed_next = 1'b0;
                    if (!changed_reg)
                    begin
                        any_next   = 1'b0;
                        hit_next   = 1'b0;
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_FINAL:
            begin
                if (rd_vld_reg)
                begin
                    active_next[rd_idx_reg] = seed_reg[rd_idx_reg] &&
                                              (rd_data_reg.kind != KIND_SPLIT);
                    if (seed_reg[rd_idx_reg] && rd_data_reg.kind != KIND_SPLIT)
                    begin
                        any_next = 1'b1;
                        if (rd_data_reg.kind == KIND_MATCH)
                        begin
                            hit_next = 1'b1;
                        end
                    end
                end
                if (scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    if (hit_reg)
                    begin
                        longest_next = position_reg;
                    end
                    match_seen_next = match_seen_reg || hit_reg;
                    end16           = END_W'(longest_next);
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_data_next[0]    = match_seen_next;
                    out_data_next[16:1] = match_seen_next ? end16 : '0;
                    out_data_next[17]   = any_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            active_reg     <= '0;
            match_seen_reg <= 1'b0;
            longest_reg    <= '0;
            position_reg   <= '0;
            start_reg      <= '0;
            out_valid_reg  <= 1'b0;
            changed_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_vld_reg     <= rd_vld_next;
            active_reg     <= active_next;
            match_seen_reg <= match_seen_next;
            longest_reg    <= longest_next;
            position_reg   <= position_next;
            out_valid_reg  <= out_valid_next;
            changed_reg    <= changed_next;
            if (cfg_valid && cfg_ready)
            begin
                start_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        seed_reg     <= seed_next;
        any_reg      <= any_next;
        hit_reg      <= hit_next;
        char_reg     <= char_next;
        out_data_reg <= out_data_next;
    end

endmodule

/* design/nfa_chk.sv */
// ----------------------------------------------------------------------------
// nfa_chk: port-level checks for the NFA prefix matcher
// Watches the stream and result ports; bound to the top level.
// ----------------------------------------------------------------------------
module nfa_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [1:0]                     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [nfa_pkg::OUT_DATA_W-1:0] m_tdata
);
    import nfa_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a load request never produces a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == CMD_LOAD && !m_tvalid |=> !m_tvalid)
        else $error("result after load");

    // a character request keeps the block busy
    a_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == CMD_CHAR |=> !s_tready)
        else $error("ready right after character");

    // no match means a zero match length
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == 16'd0)
        else $error("match_len set without match");

endmodule

bind nfa_regex_prefix_matcher nfa_chk u_nfa_chk (.*);
